>>> rtl/fla_pkg.sv
package fla_pkg;

	// Pool size and fixed field widths
	localparam int CAPACITY_DEF = 512;
	localparam int SLOT_W       = 9;
	localparam int STATUS_W     = 2;
	localparam int LIVE_W       = 10;

	// Request kinds
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ALL_FREE = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [STATUS_W-1:0] status;
		logic [LIVE_W-1:0]   live_count;
		logic                pool_full;
	} rsp_t;

endpackage

>>> rtl/free_list_index_allocator.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_t: req_type, slot_index
// rsp     | out       | rsp_valid/rsp_stall | rsp_t: granted_slot, status, live_count, pool_full
//
// One item per cycle while req_stall is low; each result passes through the read
// stage, which registers the stack memory read, and then the output register.
// Reset needs no clearing pass: entries below the lowest stack depth reached
// since reset have never been written and read back as their reset values.
// A stalled result holds the read stage; req_stall rises only while both
// the read stage and the output register are full and rsp_stall is high.
module free_list_index_allocator
	import fla_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int TOP_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int VW    = (TOP_W > SLOT_W) ? TOP_W : SLOT_W;
	localparam int LW    = (TOP_W > LIVE_W) ? TOP_W : LIVE_W;
	localparam logic [TOP_W-1:0] CAP_T = TOP_W'(CAPACITY);

	logic [SLOT_W-1:0] stack_mem [CAPACITY];

	logic [TOP_W-1:0] top_q;
	logic [TOP_W-1:0] low_q;

	logic              v_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [LIVE_W-1:0] live_s1;
	logic              full_s1;
	logic              grant_s1;
	logic              fresh_s1;
	logic [SLOT_W-1:0] fresh_val_s1;
	logic [SLOT_W-1:0] rd_s1;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic              acc;
	logic              s1_go;
	logic              is_pop;
	logic              in_range;
	logic              pop_ok;
	logic              push_ok;
	logic [STATUS_W-1:0] status_c;
	logic [TOP_W-1:0]  top_c;
	logic [TOP_W-1:0]  top_m1;
	logic [AW-1:0]     pop_addr;
	logic [AW-1:0]     push_addr;
	logic [VW-1:0]     fresh_val_c;
	logic [LW-1:0]     live_c;

	// Handshakes
	assign s1_go     = v_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = v_s1 && !s1_go;
	assign acc       = req_valid && !req_stall;

	// Decode the request against the current stack depth
	assign is_pop   = (req.req_type == REQ_ACQUIRE);
	assign in_range = 32'(req.slot_index) < 32'(CAPACITY);
	assign top_m1   = top_q - TOP_W'(1);
	assign pop_addr  = top_m1[AW-1:0];
	assign push_addr = top_q[AW-1:0];

	always_comb begin
		pop_ok   = 1'b0;
		push_ok  = 1'b0;
		status_c = ST_OK;
		top_c    = top_q;
		if (is_pop) begin
			if (top_q == '0) begin
				status_c = ST_EMPTY;
			end else begin
				pop_ok = 1'b1;
				top_c  = top_m1;
			end
		end else if (!in_range) begin
			status_c = ST_RANGE;
		end else if (top_q == CAP_T) begin
			status_c = ST_ALL_FREE;
		end else begin
			push_ok = 1'b1;
			top_c   = top_q + TOP_W'(1);
		end
	end

	// Reset value of entry top-1 is CAPACITY - top
	assign fresh_val_c = VW'(CAP_T - top_q);
	assign live_c      = LW'(CAP_T - top_c);

	// Stack depth and lowest depth reached since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CAP_T;
			low_q <= CAP_T;
		end else if (acc) begin
			top_q <= top_c;
			if (pop_ok && top_q == low_q) begin
				low_q <= top_m1;
			end
		end
	end

	// Push writes and pop reads of the stack memory
	always_ff @(posedge clk) begin
		if (acc && push_ok) begin
			stack_mem[push_addr] <= req.slot_index;
		end
		if (acc && pop_ok) begin
			rd_s1 <= stack_mem[pop_addr];
		end
	end

	// Read stage: hold until the output register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1    <= status_c;
			live_s1      <= live_c[LIVE_W-1:0];
			full_s1      <= (top_c == '0);
			grant_s1     <= pop_ok;
			fresh_s1     <= (top_q == low_q);
			fresh_val_s1 <= fresh_val_c[SLOT_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			rsp_q.granted_slot <= grant_s1 ? (fresh_s1 ? fresh_val_s1 : rd_s1) : '0;
			rsp_q.status       <= status_s1;
			rsp_q.live_count   <= live_s1;
			rsp_q.pool_full    <= full_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Depth stays within the pool
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CAP_T)
		else $error("stack depth beyond capacity");

	// Lowest depth mark never lies above the depth
	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= top_q)
		else $error("low-water mark above stack depth");

	// An accepted item occupies the read stage next cycle
	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted item lost before read stage");

	// Empty-pool result grants nothing and reports a full pool
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.pool_full && rsp.granted_slot == '0))
		else $error("empty-pool result inconsistent");

	// Read stage advances while the output side is open
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rsp_valid_q) |-> s1_go)
		else $error("read stage stuck with free output");

endmodule

>>> test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fla_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Predicted pool state: stack of free slots and the free count
	logic [SLOT_W-1:0] free_slots [CAPACITY_DEF];
	int unsigned free_count;

	// Results still to arrive, oldest first, and slots the pool has handed out
	rsp_t awaited_rsp[$];
	logic [SLOT_W-1:0] held_slots[$];

	int error_count = 0;
	int idle_cycles = 0;
	int calm_left = 0;

	free_list_index_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Load the free stack as after reset: top of stack holds slot 0
	function automatic void reset_pool();
		for (int i = 0; i < CAPACITY_DEF; i++) begin
			free_slots[i] = SLOT_W'(CAPACITY_DEF - 1 - i);
		end
		free_count = CAPACITY_DEF;
	endfunction

	// Apply one request to the predicted pool and return its result
	function automatic rsp_t allocate_step(input req_t item);
		rsp_t outcome;
		outcome = '0;
		outcome.status = ST_OK;
		if (item.req_type == REQ_ACQUIRE) begin
			if (free_count == 0) begin
				outcome.status = ST_EMPTY;
			end else begin
				free_count--;
				outcome.granted_slot = free_slots[free_count];
			end
		end else if (int'(item.slot_index) >= CAPACITY_DEF) begin
			outcome.status = ST_RANGE;
		end else if (free_count >= CAPACITY_DEF) begin
			outcome.status = ST_ALL_FREE;
		end else begin
			free_slots[free_count] = item.slot_index;
			free_count++;
		end
		outcome.live_count = LIVE_W'(CAPACITY_DEF - int'(free_count));
		outcome.pool_full = (free_count == 0);
		return outcome;
	endfunction

	// Mostly no gap, some short, a few long; now and then a calm stretch
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_req(input logic kind, input logic [SLOT_W-1:0] slot);
		req_t item;
		item.req_type = kind;
		item.slot_index = slot;
		return item;
	endfunction

	// Send one item, then predict its result and track handed-out slots
	task automatic send_req(input req_t item);
		int gap;
		rsp_t outcome;
		int found[$];
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		outcome = allocate_step(item);
		awaited_rsp.push_back(outcome);
		if (outcome.status == ST_OK) begin
			if (item.req_type == REQ_ACQUIRE) begin
				held_slots.push_back(outcome.granted_slot);
			end else begin
				found = held_slots.find_first_index(s) with (s == item.slot_index);
				if (found.size() != 0) held_slots.delete(found[0]);
			end
		end
	endtask

	// Hold the sender until every outstanding result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	// Release into a full free list, reset hand-out order, reuse of returned slots
	task automatic test_directed_cases();
		send_req(make_req(REQ_RELEASE, 9'd0));
		send_req(make_req(REQ_RELEASE, 9'h1FF));
		send_req(make_req(REQ_ACQUIRE, 9'h1FF));
		send_req(make_req(REQ_ACQUIRE, 9'h000));
		send_req(make_req(REQ_ACQUIRE, 9'h155));
		send_req(make_req(REQ_RELEASE, 9'h1FF));
		send_req(make_req(REQ_ACQUIRE, 9'h0AA));
		send_req(make_req(REQ_RELEASE, 9'd1));
		send_req(make_req(REQ_RELEASE, 9'h155));
		send_req(make_req(REQ_RELEASE, 9'h0AA));
		send_req(make_req(REQ_ACQUIRE, 9'd0));
		send_req(make_req(REQ_ACQUIRE, 9'd0));
		send_req(make_req(REQ_ACQUIRE, 9'd0));
		// return a slot that is already free: it is pushed a second time
		send_req(make_req(REQ_RELEASE, 9'd300));
		send_req(make_req(REQ_ACQUIRE, 9'd0));
		send_req(make_req(REQ_RELEASE, 9'd2));
		send_req(make_req(REQ_RELEASE, 9'd0));
		send_req(make_req(REQ_RELEASE, 9'h1FF));
		send_req(make_req(REQ_RELEASE, 9'h0AA));
		send_req(make_req(REQ_RELEASE, 9'h155));
		send_req(make_req(REQ_RELEASE, 9'd1));
		send_req(make_req(REQ_RELEASE, 9'd300));
		// every slot is free again, so this one is refused
		send_req(make_req(REQ_RELEASE, 9'd7));
		// with 9-bit slot numbers and 512 slots no index is out of range
		wait_drained();
	endtask

	// Mix acquires with releases of held slots, plus some stray releases
	task automatic test_random_mix(input int count, input int acquire_pct);
		logic [SLOT_W-1:0] slot;
		for (int n = 0; n < count; n++) begin
			slot = SLOT_W'($urandom);
			if ($urandom_range(99) < acquire_pct) begin
				send_req(make_req(REQ_ACQUIRE, slot));
			end else if (held_slots.size() != 0 && $urandom_range(99) < 85) begin
				slot = held_slots[$urandom_range(held_slots.size() - 1)];
				send_req(make_req(REQ_RELEASE, slot));
			end else begin
				send_req(make_req(REQ_RELEASE, slot));
			end
		end
	endtask

	// Acquire until no slot is free, then keep asking an empty pool
	task automatic test_fill_pool();
		while (free_count != 0) begin
			send_req(make_req(REQ_ACQUIRE, SLOT_W'($urandom)));
		end
		repeat (6) send_req(make_req(REQ_ACQUIRE, SLOT_W'($urandom)));
		wait_drained();
	endtask

	// Stall the result side in runs: short and long stalls, calm stretches
	initial begin
		int r;
		int len;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(99);
			if (r < 30) begin
				rsp_stall <= 1'b0;
				len = $urandom_range(1, 4);
			end else if (r < 45) begin
				rsp_stall <= 1'b0;
				len = $urandom_range(20, 80);
			end else if (r < 90) begin
				rsp_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				rsp_stall <= 1'b1;
				len = $urandom_range(10, 30);
			end
			repeat (len) @(posedge clk);
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t ERROR: unexpected result %p", $time, rsp);
				error_count++;
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.granted_slot !== want.granted_slot) begin
					$display("%0t ERROR: granted_slot expected %0d actual %0d",
						$time, want.granted_slot, rsp.granted_slot);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t ERROR: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					error_count++;
				end
				if (rsp.live_count !== want.live_count) begin
					$display("%0t ERROR: live_count expected %0d actual %0d",
						$time, want.live_count, rsp.live_count);
					error_count++;
				end
				if (rsp.pool_full !== want.pool_full) begin
					$display("%0t ERROR: pool_full expected %0b actual %0b",
						$time, want.pool_full, rsp.pool_full);
					error_count++;
				end
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ERROR: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		reset_pool();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_mix(200, 50);
		test_fill_pool();
		test_random_mix(220, 25);

		// Drain, let the pipeline settle, and report
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_rsp.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
